/* hw/rtl/fvr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fvr_pkg
// Types and constants shared by the vertex rotate and project pipeline.
// ----------------------------------------------------------------------------
package fvr_pkg;

	localparam int FIX_W  = 32;
	localparam int COEF_W = 18;
	localparam int ROW_W  = 3 * COEF_W;
	localparam int PROD_W = FIX_W + COEF_W;
	localparam int SCR_W  = 16;
	localparam int FRAC_W = 16;
	localparam int IDX_W  = 3;
	localparam int DIM    = 3;

	typedef logic signed [FIX_W-1:0]  word_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [SCR_W-1:0]  scr_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [IDX_W-1:0]         reg_idx_t;

	typedef word_t prod_row_t [DIM];
	typedef prod_row_t prod_mat_t [DIM];

	typedef struct packed {
		scr_t h;
		scr_t v;
	} origin_t;

	localparam reg_idx_t REG_ROW0     = 3'd0;
	localparam reg_idx_t REG_ROW1     = 3'd1;
	localparam reg_idx_t REG_ROW2     = 3'd2;
	localparam reg_idx_t REG_ORIGIN_H = 3'd3;
	localparam reg_idx_t REG_ORIGIN_V = 3'd4;

	// identity matrix, 1.0 on the diagonal
	localparam row_t ROW0_RST = row_t'(1) << FRAC_W;
	localparam row_t ROW1_RST = row_t'(1) << (FRAC_W + COEF_W);
	localparam row_t ROW2_RST = row_t'(1) << (FRAC_W + 2 * COEF_W);

	localparam logic signed [PROD_W:0] PROD_HALF = (PROD_W+1)'(1) << (FRAC_W - 1);
	localparam logic signed [FIX_W:0]  WORD_HALF = (FIX_W+1)'(1) << (FRAC_W - 1);

endpackage
`default_nettype wire

/* hw/rtl/fixed_point_vertex_rotate_project_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_vertex_rotate_project_top
// Rotates a 16.16 vertex by a configured 3x3 matrix of 2.16 entries and
// projects it to a 16-bit screen point.
//
// channel  direction  handshake              word
// in       input      in_valid / in_stall    in_x, in_y, in_z
// out      output     out_valid / out_stall  out_x, out_y, out_z, screen_h, screen_v
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// One vertex per cycle while no output word is stalled; stages: multiply,
// round and saturate, row sum, projection into the output register.
// The pipeline advances as a whole; a stalled output word holds every stage,
// and in_stall rises only while a word waits at the output.
// Reset loads the identity matrix and a zero origin and clears all valid bits.
// ----------------------------------------------------------------------------
module fixed_point_vertex_rotate_project_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire fvr_pkg::word_t     in_x,
	input  wire fvr_pkg::word_t     in_y,
	input  wire fvr_pkg::word_t     in_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output fvr_pkg::word_t          out_x,
	output fvr_pkg::word_t          out_y,
	output fvr_pkg::word_t          out_z,
	output fvr_pkg::scr_t           screen_h,
	output fvr_pkg::scr_t           screen_v,
	input  wire logic               cfg_we,
	input  wire fvr_pkg::reg_idx_t  cfg_index,
	input  wire fvr_pkg::row_t      cfg_data
);
	import fvr_pkg::*;

	row_t      row_q [DIM];
	origin_t   origin_q;
	logic      vld_s1;
	logic      vld_s2;
	logic      vld_s3;
	logic      vld_s4;
	logic      en;
	logic      en_in;
	word_t     vec [DIM];
	prod_mat_t prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
			origin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0:     row_q[0]   <= cfg_data;
				REG_ROW1:     row_q[1]   <= cfg_data;
				REG_ROW2:     row_q[2]   <= cfg_data;
				REG_ORIGIN_H: origin_q.h <= cfg_data[SCR_W-1:0];
				REG_ORIGIN_V: origin_q.v <= cfg_data[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !vld_s4 || !out_stall;
	assign in_stall = !en;
	assign en_in    = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= en_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign vec[0] = in_x;
	assign vec[1] = in_y;
	assign vec[2] = in_z;

	for (genvar r = 0; r < DIM; r++) begin : g_row
		for (genvar c = 0; c < DIM; c++) begin : g_col
			fvr_prod u_prod (
				.clk  (clk),
				.en   (en),
				.coef (row_q[r][c*COEF_W +: COEF_W]),
				.val  (vec[c]),
				.prod (prod[r][c])
			);
		end
	end

	fvr_proj u_proj (
		.clk      (clk),
		.en       (en),
		.prod     (prod),
		.origin   (origin_q),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z),
		.screen_h (screen_h),
		.screen_v (screen_v)
	);

	assign out_valid = vld_s4;

endmodule
`default_nettype wire

/* hw/rtl/fvr_prod.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fvr_prod
// One matrix product: registered 18x32 multiply, then round to 16.16 and
// saturate to 32 bits in the next stage.
// ----------------------------------------------------------------------------
module fvr_prod (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire fvr_pkg::coef_t coef,
	input  wire fvr_pkg::word_t val,
	output fvr_pkg::word_t     prod
);
	import fvr_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W:0]   rnd;
	logic signed [PROD_W-FRAC_W:0] shf;
	word_t                    sat_s2;
	logic                     ovf;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(coef) * PROD_W'(val);
		end
	end

	always_comb begin
		rnd = (PROD_W+1)'(prod_s1) + PROD_HALF;
		shf = rnd[PROD_W:FRAC_W];
		ovf = (shf[PROD_W-FRAC_W:FIX_W-1] != '0) && (shf[PROD_W-FRAC_W:FIX_W-1] != '1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf) begin
				sat_s2 <= shf[PROD_W-FRAC_W] ? {1'b1, {(FIX_W-1){1'b0}}}
				                             : {1'b0, {(FIX_W-1){1'b1}}};
			end else begin
				sat_s2 <= shf[FIX_W-1:0];
			end
		end
	end

	assign prod = sat_s2;

endmodule
`default_nettype wire

/* hw/rtl/fvr_proj.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fvr_proj
// Row sums of the saturated products, then screen projection and the
// output register.
// ----------------------------------------------------------------------------
module fvr_proj (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire fvr_pkg::prod_mat_t prod,
	input  wire fvr_pkg::origin_t  origin,
	output fvr_pkg::word_t         out_x,
	output fvr_pkg::word_t         out_y,
	output fvr_pkg::word_t         out_z,
	output fvr_pkg::scr_t          screen_h,
	output fvr_pkg::scr_t          screen_v
);
	import fvr_pkg::*;

	word_t               sum_s3 [DIM];
	word_t               x_s4;
	word_t               y_s4;
	word_t               z_s4;
	scr_t                h_s4;
	scr_t                v_s4;
	word_t               nz;
	logic signed [FIX_W:0] ry_rnd;
	logic signed [FIX_W:0] nz_rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < DIM; r++) begin
				sum_s3[r] <= prod[r][0] + prod[r][1] + prod[r][2];
			end
		end
	end

	always_comb begin
		nz     = -sum_s3[2];
		ry_rnd = (FIX_W+1)'(sum_s3[1]) + WORD_HALF;
		nz_rnd = (FIX_W+1)'(nz) + WORD_HALF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4 <= sum_s3[0];
			y_s4 <= sum_s3[1];
			z_s4 <= sum_s3[2];
			h_s4 <= ry_rnd[FRAC_W+SCR_W-1:FRAC_W] + origin.h;
			v_s4 <= nz_rnd[FRAC_W+SCR_W-1:FRAC_W] + origin.v;
		end
	end

	assign out_x    = x_s4;
	assign out_y    = y_s4;
	assign out_z    = z_s4;
	assign screen_h = h_s4;
	assign screen_v = v_s4;

endmodule
`default_nettype wire

/* hw/rtl/fvr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fvr_checker
// Port-level checks of the vertex rotate pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module fvr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output word");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("accepted word did not reach the output in four cycles");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("pipeline not empty after reset");

endmodule

bind fixed_point_vertex_rotate_project_top fvr_checker u_fvr_checker (.*);
`default_nettype wire

/* sim/tb_fixed_point_vertex_rotate_project_top.sv */
// ----------------------------------------------------------------------------
// tb_fixed_point_vertex_rotate_project_top
// Streams vertices through the rotate and project pipeline under several
// matrix and origin settings, with random gaps on both sides and one long
// output hold. A scoreboard predicts each rotated vertex and screen point
// and compares every output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fixed_point_vertex_rotate_project_top;
	import fvr_pkg::*;

	localparam coef_t COEF_MAX     = coef_t'((1 << (COEF_W - 1)) - 1);
	localparam coef_t COEF_MIN     = coef_t'(1 << (COEF_W - 1));
	localparam coef_t COEF_ONE     = coef_t'(1 << FRAC_W);
	localparam coef_t COEF_LSB     = coef_t'(1);
	localparam coef_t COEF_NEG_LSB = coef_t'(-1);
	localparam coef_t COEF_ZERO    = coef_t'(0);
	localparam word_t WORD_MAX     = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN     = 32'sh8000_0000;
	localparam word_t WORD_HALF_UP = 32'sh0000_8000;
	localparam word_t WORD_HALF_DN = 32'shFFFF_8000;
	localparam scr_t  SCR_MAX      = 16'sh7FFF;
	localparam scr_t  SCR_MIN      = 16'sh8000;
	localparam longint ROUND_HALF  = 64'sd32768;
	localparam int RAND_PHASES     = 6;
	localparam int PHASE_ITEMS     = 175;
	localparam int LONG_HOLD       = 60;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		scr_t  h;
		scr_t  v;
	} vertex_result_t;

	class vertex_scoreboard;
		row_t rows [DIM];
		scr_t org_h;
		scr_t org_v;
		vertex_result_t pending [$];
		int unsigned errors;
		int unsigned noted;
		int unsigned checked;

		function void reset_regs();
			rows[0] = ROW0_RST;
			rows[1] = ROW1_RST;
			rows[2] = ROW2_RST;
			org_h = '0;
			org_v = '0;
		endfunction

		function void write_reg(reg_idx_t idx, row_t data);
			case (idx)
				REG_ROW0: rows[0] = data;
				REG_ROW1: rows[1] = data;
				REG_ROW2: rows[2] = data;
				REG_ORIGIN_H: org_h = scr_t'(data[SCR_W-1:0]);
				REG_ORIGIN_V: org_v = scr_t'(data[SCR_W-1:0]);
				default: ;
			endcase
		endfunction

		function word_t scaled_product(coef_t c, word_t w);
			longint p;
			p = longint'(c) * longint'(w);
			p = (p + ROUND_HALF) >>> FRAC_W;
			if (p > longint'(WORD_MAX))
				p = longint'(WORD_MAX);
			else if (p < longint'(WORD_MIN))
				p = longint'(WORD_MIN);
			return word_t'(p);
		endfunction

		function word_t row_dot(row_t r, word_t x, word_t y, word_t z);
			word_t acc;
			acc = scaled_product(coef_t'(r[0 +: COEF_W]), x)
				+ scaled_product(coef_t'(r[COEF_W +: COEF_W]), y)
				+ scaled_product(coef_t'(r[2*COEF_W +: COEF_W]), z);
			return acc;
		endfunction

		function scr_t to_screen(word_t f, scr_t org);
			longint t;
			scr_t s;
			t = (longint'(f) + ROUND_HALF) >>> FRAC_W;
			s = scr_t'(t) + org;
			return s;
		endfunction

		function void note_vertex(word_t x, word_t y, word_t z);
			vertex_result_t r;
			word_t nz;
			r.x = row_dot(rows[0], x, y, z);
			r.y = row_dot(rows[1], x, y, z);
			r.z = row_dot(rows[2], x, y, z);
			nz = -r.z;
			r.h = to_screen(r.y, org_h);
			r.v = to_screen(nz, org_v);
			pending.push_back(r);
			noted++;
		endfunction

		function void check_result(vertex_result_t got);
			vertex_result_t exp_r;
			if (pending.size() == 0) begin
				$error("output word with no vertex pending");
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got.x !== exp_r.x) begin
				$error("out_x expected %0d actual %0d", exp_r.x, got.x);
				errors++;
			end
			if (got.y !== exp_r.y) begin
				$error("out_y expected %0d actual %0d", exp_r.y, got.y);
				errors++;
			end
			if (got.z !== exp_r.z) begin
				$error("out_z expected %0d actual %0d", exp_r.z, got.z);
				errors++;
			end
			if (got.h !== exp_r.h) begin
				$error("screen_h expected %0d actual %0d", exp_r.h, got.h);
				errors++;
			end
			if (got.v !== exp_r.v) begin
				$error("screen_v expected %0d actual %0d", exp_r.v, got.v);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	word_t in_x;
	word_t in_y;
	word_t in_z;
	logic out_valid;
	logic out_stall;
	word_t out_x;
	word_t out_y;
	word_t out_z;
	scr_t screen_h;
	scr_t screen_v;
	logic cfg_we;
	reg_idx_t cfg_index;
	row_t cfg_data;

	vertex_scoreboard rotate_sb;
	int in_gap_max;
	int out_gap_max;
	int hold_request;
	int unsigned cfg_writes;

	fixed_point_vertex_rotate_project_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_x(in_x),
		.in_y(in_y),
		.in_z(in_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.screen_h(screen_h),
		.screen_v(screen_v),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	task send_vertex(word_t x, word_t y, word_t z);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		do @(posedge clk); while (in_stall);
		rotate_sb.note_vertex(x, y, z);
	endtask

	task write_reg(reg_idx_t idx, row_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		rotate_sb.write_reg(idx, data);
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (rotate_sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task load_config(row_t r0, row_t r1, row_t r2, scr_t oh, scr_t ov);
		row_t junk;
		write_reg(REG_ROW0, r0);
		write_reg(REG_ROW1, r1);
		write_reg(REG_ROW2, r2);
		junk = row_t'({$urandom, $urandom});
		junk[SCR_W-1:0] = oh;
		write_reg(REG_ORIGIN_H, junk);
		junk = row_t'({$urandom, $urandom});
		junk[SCR_W-1:0] = ov;
		write_reg(REG_ORIGIN_V, junk);
	endtask

	task write_stray();
		int i;
		for (i = REG_ORIGIN_V + 1; i < (1 << IDX_W); i++)
			write_reg(reg_idx_t'(i), row_t'({$urandom, $urandom}));
	endtask

	function row_t make_row(coef_t c0, coef_t c1, coef_t c2);
		return row_t'({c2, c1, c0});
	endfunction

	function coef_t rand_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return coef_t'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
			3: return ($urandom_range(0, 1) != 0) ? COEF_ONE : -COEF_ONE;
			default: return coef_t'($urandom);
		endcase
	endfunction

	function word_t rand_word();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			1: return word_t'($urandom_range(0, 1 << 22)) - word_t'(1 << 21);
			2: return {16'($urandom), 16'h8000};
			default: return word_t'($urandom);
		endcase
	endfunction

	function scr_t rand_origin();
		case ($urandom_range(0, 3))
			0: return SCR_MAX;
			1: return SCR_MIN;
			default: return scr_t'($urandom);
		endcase
	endfunction

	initial begin
		vertex_result_t got;
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
			end else begin
				n = $urandom_range(0, out_gap_max);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			got.x = out_x;
			got.y = out_y;
			got.z = out_z;
			got.h = screen_h;
			got.v = screen_v;
			rotate_sb.check_result(got);
		end
	end

	initial begin
		#400000;
		$display("FAIL fixed_point_vertex_rotate_project_top");
		$finish;
	end

	initial begin
		int p;
		int k;
		rotate_sb = new();
		rotate_sb.reset_regs();
		in_gap_max = 6;
		out_gap_max = 6;
		hold_request = 0;
		cfg_writes = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_x <= '0;
		in_y <= '0;
		in_z <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROW0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// identity after reset: screen rounding, most negative z
		send_vertex('0, '0, '0);
		send_vertex(WORD_MAX, WORD_MIN, -1);
		send_vertex(WORD_MIN, WORD_MAX, WORD_MIN);
		send_vertex(WORD_HALF_UP, WORD_HALF_DN, 32'sh0001_8000);
		send_vertex(32'sh7FFF_8000, 32'sh7FFF_7FFF, 32'sh8000_8000);
		drain();

		// saturation, half rounding of products, row sum wrap, screen wrap
		load_config(make_row(COEF_ONE, COEF_ONE, COEF_ONE),
			make_row(COEF_LSB, COEF_MAX, COEF_MIN),
			make_row(COEF_MIN, COEF_NEG_LSB, COEF_ZERO), SCR_MAX, SCR_MIN);
		send_vertex(WORD_HALF_UP, WORD_MAX, WORD_MIN);
		send_vertex(WORD_HALF_DN, WORD_MIN, WORD_MAX);
		send_vertex(WORD_MAX, WORD_MAX, WORD_MAX);
		send_vertex(WORD_MIN, WORD_MIN, WORD_MIN);
		send_vertex(32'sh0000_8001, WORD_HALF_UP, WORD_HALF_DN);
		send_vertex(-1, 1, 32'sh0000_7FFF);
		send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh4000_0000);
		drain();

		load_config(make_row(COEF_MAX, COEF_MAX, COEF_MAX),
			make_row(COEF_MIN, COEF_MIN, COEF_MIN),
			make_row(COEF_NEG_LSB, COEF_LSB, COEF_ONE), SCR_MIN, SCR_MAX);
		write_stray();
		send_vertex(WORD_MAX, WORD_MAX, WORD_MAX);
		send_vertex(WORD_MIN, WORD_MIN, WORD_MIN);
		send_vertex(WORD_MAX, WORD_MIN, WORD_HALF_UP);
		send_vertex(32'sh0000_8000, 32'sh0000_8000, WORD_HALF_DN);
		send_vertex(1, -1, '0);
		drain();

		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				1: load_config(make_row(COEF_MAX, COEF_MAX, COEF_MAX),
					make_row(COEF_MAX, COEF_MAX, COEF_MAX),
					make_row(COEF_MAX, COEF_MAX, COEF_MAX), SCR_MAX, SCR_MAX);
				2: load_config(make_row(COEF_MIN, COEF_MIN, COEF_MIN),
					make_row(COEF_MIN, COEF_MIN, COEF_MIN),
					make_row(COEF_MIN, COEF_MIN, COEF_MIN), SCR_MIN, SCR_MIN);
				default: load_config(make_row(rand_coef(), rand_coef(), rand_coef()),
					make_row(rand_coef(), rand_coef(), rand_coef()),
					make_row(rand_coef(), rand_coef(), rand_coef()),
					rand_origin(), rand_origin());
			endcase
			if (p == 5)
				write_stray();
			in_gap_max = (p == 3 || p == 4) ? 0 : 6;
			out_gap_max = (p == 3) ? 0 : 6;
			if (p == 4)
				hold_request = LONG_HOLD;
			for (k = 0; k < PHASE_ITEMS; k++)
				send_vertex(rand_word(), rand_word(), rand_word());
			drain();
		end

		$display("Ran %0d vertices through %0d register writes across %0d settings,",
			rotate_sb.noted, cfg_writes, RAND_PHASES + 3);
		$display("with idle and stall gaps, one long output hold, %0d words checked.",
			rotate_sb.checked);
		if (rotate_sb.errors == 0 && rotate_sb.pending.size() == 0)
			$display("PASS fixed_point_vertex_rotate_project_top");
		else
			$display("FAIL fixed_point_vertex_rotate_project_top");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/fvr_pkg.sv
hw/rtl/fvr_prod.sv
hw/rtl/fvr_proj.sv
hw/rtl/fixed_point_vertex_rotate_project_top.sv
hw/rtl/fvr_checker.sv
sim/tb_fixed_point_vertex_rotate_project_top.sv
